// File: design/pidaw_pkg.sv
package pidaw_pkg;

  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int DB_W      = 8;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int FRAC_W    = 8;

  // full-scale count of the encoder circle
  localparam int ENCODER_COUNTS_DEF = 8192;

  localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(3);

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INT_LIMIT  = 3'd3,
    REG_OUT_LIMIT  = 3'd4,
    REG_ANGLE_MODE = 3'd5,
    REG_DEADBAND   = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_e;

endpackage

// File: design/pidaw_err_front.sv
module pidaw_err_front #(
  parameter int ENCODER_COUNTS = pidaw_pkg::ENCODER_COUNTS_DEF
) (
  input  logic signed [pidaw_pkg::DATA_W-1:0] target_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measured_i,
  input  logic                                angle_mode_i,
  input  logic        [pidaw_pkg::DB_W-1:0]   deadband_i,
  output logic signed [pidaw_pkg::ERR_W-1:0]  err_o
);

  localparam int WW = pidaw_pkg::ERR_W + 1;
  localparam logic signed [WW-1:0] ENC  = WW'(ENCODER_COUNTS);
  localparam logic signed [WW-1:0] HALF = WW'(ENCODER_COUNTS / 2);

  logic signed [WW-1:0] raw;
  logic signed [WW-1:0] wrapped;
  logic signed [WW-1:0] db;

  assign raw = WW'(target_i) - WW'(measured_i);
  assign db  = $signed({{(WW - pidaw_pkg::DB_W){1'b0}}, deadband_i});

  always_comb begin
    wrapped = raw;
    if (angle_mode_i) begin
      // single wrap onto the encoder circle, boundary values left alone
      if (raw > HALF) begin
        wrapped = raw - ENC;
      end else if (raw < -HALF) begin
        wrapped = raw + ENC;
      end
      if ((wrapped < db) && (wrapped > -db)) begin
        wrapped = '0;
      end
    end
  end

  assign err_o = wrapped[pidaw_pkg::ERR_W-1:0];

endmodule

// File: design/positional_pid_angle_wrap.sv
// Positional PID with optional angle wrap: each beat on the input carries a target and a
// measurement, and one beat with the clamped drive and the error used leaves once it has
// passed every stage. The pipeline takes a new beat every cycle while the output is not
// stalled; its stages are error forming (wrap and deadband), the three gain multiplies,
// the integral add and clamp with the p plus d sum, and the output sum, clamp and shift.
// The integral accumulator closes its loop within the integral stage, which is what allows
// one beat per cycle. Registers sit on an APB-style port at byte addresses 0x00 to 0x18
// and must only be written while the pipeline is empty.
module positional_pid_angle_wrap #(
  parameter int ENCODER_COUNTS = pidaw_pkg::ENCODER_COUNTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [pidaw_pkg::APB_AW-1:0]  paddr,
  input  logic        [pidaw_pkg::APB_DW-1:0]  pwdata,
  output logic        [pidaw_pkg::APB_DW-1:0]  prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pidaw_pkg::DATA_W-1:0]  target_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0]  measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pidaw_pkg::DATA_W-1:0]  drive_o,
  output logic signed [pidaw_pkg::ERR_W-1:0]   error_now_o
);

  localparam int EW  = pidaw_pkg::ERR_W;
  localparam int GW  = pidaw_pkg::GAIN_W;
  localparam int LW  = pidaw_pkg::LIM_W;
  localparam int FW  = pidaw_pkg::FRAC_W;
  localparam int DW  = pidaw_pkg::DATA_W;
  localparam int PW  = EW + GW + 1;      // err times gain
  localparam int DFW = EW + 1;           // error change
  localparam int PDW = DFW + GW + 1;     // change times gain
  localparam int IAW = LW + FW + 2;      // stored integral
  localparam int ISW = PW + 1;           // integral sum before clamp
  localparam int PSW = PDW + 1;          // p plus d
  localparam int SW  = PSW + 1;          // full sum before clamp

  // configuration
  logic        [GW-1:0]         gain_p_q, gain_i_q, gain_d_q;
  logic        [LW-1:0]         int_limit_q, out_limit_q;
  logic                         angle_mode_q;
  logic        [pidaw_pkg::DB_W-1:0] deadband_q;
  pidaw_pkg::reg_idx_e          reg_idx;
  logic                         cfg_wr;

  assign reg_idx = pidaw_pkg::reg_idx_e'(paddr[pidaw_pkg::APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      int_limit_q  <= '0;
      out_limit_q  <= '0;
      angle_mode_q <= 1'b0;
      deadband_q   <= pidaw_pkg::DEADBAND_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pidaw_pkg::REG_GAIN_P:     gain_p_q     <= pwdata[GW-1:0];
        pidaw_pkg::REG_GAIN_I:     gain_i_q     <= pwdata[GW-1:0];
        pidaw_pkg::REG_GAIN_D:     gain_d_q     <= pwdata[GW-1:0];
        pidaw_pkg::REG_INT_LIMIT:  int_limit_q  <= pwdata[LW-1:0];
        pidaw_pkg::REG_OUT_LIMIT:  out_limit_q  <= pwdata[LW-1:0];
        pidaw_pkg::REG_ANGLE_MODE: angle_mode_q <= pwdata[0];
        pidaw_pkg::REG_DEADBAND:   deadband_q   <= pwdata[pidaw_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      pidaw_pkg::REG_GAIN_P:     prdata = pidaw_pkg::APB_DW'(gain_p_q);
      pidaw_pkg::REG_GAIN_I:     prdata = pidaw_pkg::APB_DW'(gain_i_q);
      pidaw_pkg::REG_GAIN_D:     prdata = pidaw_pkg::APB_DW'(gain_d_q);
      pidaw_pkg::REG_INT_LIMIT:  prdata = pidaw_pkg::APB_DW'(int_limit_q);
      pidaw_pkg::REG_OUT_LIMIT:  prdata = pidaw_pkg::APB_DW'(out_limit_q);
      pidaw_pkg::REG_ANGLE_MODE: prdata = pidaw_pkg::APB_DW'(angle_mode_q);
      pidaw_pkg::REG_DEADBAND:   prdata = pidaw_pkg::APB_DW'(deadband_q);
      default:                   prdata = '0;
    endcase
  end

  // pipeline flow: a stage loads when it is empty or its contents move on
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: error forming
  logic signed [EW-1:0] err_d;
  logic signed [EW-1:0] err1_q, prev1_q, prev_err_q;
  logic                 in_beat;

  pidaw_err_front #(
    .ENCODER_COUNTS(ENCODER_COUNTS)
  ) u_err_front (
    .target_i    (target_i),
    .measured_i  (measured_i),
    .angle_mode_i(angle_mode_q),
    .deadband_i  (deadband_q),
    .err_o       (err_d)
  );

  assign in_beat = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (in_beat) begin
      prev_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      err1_q  <= err_d;
      prev1_q <= prev_err_q;
    end
  end

  // stage 2: gain multiplies
  logic signed [GW:0]    gp_s, gi_s, gd_s;
  logic signed [DFW-1:0] diff;
  logic signed [PW-1:0]  pp_d, pi_d;
  logic signed [PDW-1:0] pd_d;
  logic signed [PW-1:0]  pp2_q, pi2_q;
  logic signed [PDW-1:0] pd2_q;
  logic signed [EW-1:0]  err2_q;

  assign gp_s = $signed({1'b0, gain_p_q});
  assign gi_s = $signed({1'b0, gain_i_q});
  assign gd_s = $signed({1'b0, gain_d_q});
  assign diff = DFW'(err1_q) - DFW'(prev1_q);
  assign pp_d = PW'(err1_q) * PW'(gp_s);
  assign pi_d = PW'(err1_q) * PW'(gi_s);
  assign pd_d = PDW'(diff) * PDW'(gd_s);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pp2_q  <= pp_d;
      pi2_q  <= pi_d;
      pd2_q  <= pd_d;
      err2_q <= err1_q;
    end
  end

  // stage 3: integral add and clamp, p plus d
  logic signed [ISW-1:0] integ_sum, ilim_s, integ_c;
  logic signed [IAW-1:0] integ_acc_q, integ3_q;
  logic signed [PSW-1:0] pdp3_q;
  logic signed [EW-1:0]  err3_q;
  logic                  s3_load;

  assign ilim_s    = $signed({{(ISW - LW - FW){1'b0}}, int_limit_q, {FW{1'b0}}});
  assign integ_sum = ISW'(integ_acc_q) + ISW'(pi2_q);

  always_comb begin
    integ_c = integ_sum;
    if (integ_sum < -ilim_s) begin
      integ_c = -ilim_s;
    end else if (integ_sum >= ilim_s) begin
      integ_c = ilim_s;
    end
  end

  assign s3_load = en3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q <= '0;
    end else if (s3_load) begin
      integ_acc_q <= integ_c[IAW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      integ3_q <= integ_c[IAW-1:0];
      pdp3_q   <= PSW'(pd2_q) + PSW'(pp2_q);
      err3_q   <= err2_q;
    end
  end

  // stage 4: output sum, clamp and floor shift
  logic signed [SW-1:0] sum, olim_s, sum_c;
  logic signed [DW-1:0] drive_q;
  logic signed [EW-1:0] err4_q;

  assign olim_s = $signed({{(SW - LW - FW){1'b0}}, out_limit_q, {FW{1'b0}}});
  assign sum    = SW'(pdp3_q) + SW'(integ3_q);

  always_comb begin
    sum_c = sum;
    if (sum < -olim_s) begin
      sum_c = -olim_s;
    end else if (sum >= olim_s) begin
      sum_c = olim_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      // clamped value fits in the drive width after the shift
      drive_q <= sum_c[DW+FW-1:FW];
      err4_q  <= err3_q;
    end
  end

  assign drive_o     = drive_q;
  assign error_now_o = err4_q;

endmodule

// File: sim/tb_top.sv
module tb_top;

  localparam int DATA_W = pidaw_pkg::DATA_W;
  localparam int ERR_W  = pidaw_pkg::ERR_W;
  localparam int APB_AW = pidaw_pkg::APB_AW;
  localparam int APB_DW = pidaw_pkg::APB_DW;
  localparam int FRAC_W = pidaw_pkg::FRAC_W;
  localparam int ENC_COUNTS = pidaw_pkg::ENCODER_COUNTS_DEF;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [ERR_W-1:0]  err;
  } pid_out_t;

  typedef struct {
    int kp;
    int ki;
    int kd;
    int ilim;
    int olim;
    int angle;
    int dband;
  } pid_regs_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] target_i = '0;
  logic signed [DATA_W-1:0] measured_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;
  logic signed [ERR_W-1:0]  error_now_o;

  // controller mirror: register copy and loop state
  pid_regs_t regs = '{0, 0, 0, 0, 0, 0, 3};
  int        prev_err = 0;
  int        integ_acc = 0;

  pid_out_t  pending_drive_q[$];
  int        mismatch_cnt = 0;
  int        checked_cnt = 0;
  int        sent_cnt = 0;
  int        setting_cnt = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  logic      rx_hold = 1'b0;

  positional_pid_angle_wrap uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .error_now_o (error_now_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v < -lim) return -lim;
    if (v >= lim) return lim;
    return v;
  endfunction

  function automatic pid_out_t pid_predict(logic signed [DATA_W-1:0] tgt,
                                           logic signed [DATA_W-1:0] meas);
    longint   e;
    longint   integ_n;
    longint   total;
    longint   half;
    pid_out_t r;
    half = ENC_COUNTS / 2;
    e = longint'(tgt) - longint'(meas);
    if (regs.angle != 0) begin
      // single wrap only, a difference of exactly half stays put
      if (e > half) e -= ENC_COUNTS;
      else if (e < -half) e += ENC_COUNTS;
      if (e < regs.dband && e > -regs.dband) e = 0;
    end
    integ_n = clamp_sym(integ_acc + e * regs.ki, longint'(regs.ilim) * 256);
    total = (e - prev_err) * regs.kd + e * regs.kp + integ_n;
    total = clamp_sym(total, longint'(regs.olim) * 256);
    prev_err = int'(e);
    integ_acc = int'(integ_n);
    r.drive = DATA_W'(total >>> FRAC_W);
    r.err = ERR_W'(e);
    return r;
  endfunction

  always @(posedge clk_i) begin : drive_check
    pid_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive_q.size() == 0) begin
        $display("%0t: unexpected beat drive %0d error %0d", $time, drive_o, error_now_o);
        mismatch_cnt++;
      end else begin
        want = pending_drive_q.pop_front();
        checked_cnt++;
        if (drive_o !== want.drive) begin
          $display("%0t: drive expected %0d got %0d", $time, want.drive, drive_o);
          mismatch_cnt++;
        end
        if (error_now_o !== want.err) begin
          $display("%0t: error_now expected %0d got %0d", $time, want.err, error_now_o);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] meas);
    // each offered cycle is idle with the given chance
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i <= tgt;
    measured_i <= meas;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_drive_q.push_back(pid_predict(tgt, meas));
    sent_cnt++;
  endtask

  task automatic send_error(input int base, input int e);
    send_sample(DATA_W'(base + e), DATA_W'(base));
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // back-to-back writes keep psel high, the caller closes the transfer
  task automatic reg_write(input pidaw_pkg::reg_idx_e idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      pidaw_pkg::REG_GAIN_P:     regs.kp = val & 16'hffff;
      pidaw_pkg::REG_GAIN_I:     regs.ki = val & 16'hffff;
      pidaw_pkg::REG_GAIN_D:     regs.kd = val & 16'hffff;
      pidaw_pkg::REG_INT_LIMIT:  regs.ilim = val & 15'h7fff;
      pidaw_pkg::REG_OUT_LIMIT:  regs.olim = val & 15'h7fff;
      pidaw_pkg::REG_ANGLE_MODE: regs.angle = val & 1;
      pidaw_pkg::REG_DEADBAND:   regs.dband = val & 8'hff;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int kp, input int ki, input int kd, input int ilim,
                                input int olim, input int angle, input int dband);
    drain_pipeline();
    reg_write(pidaw_pkg::REG_GAIN_P, kp);
    reg_write(pidaw_pkg::REG_GAIN_I, ki);
    reg_write(pidaw_pkg::REG_GAIN_D, kd);
    reg_write(pidaw_pkg::REG_INT_LIMIT, ilim);
    reg_write(pidaw_pkg::REG_OUT_LIMIT, olim);
    reg_write(pidaw_pkg::REG_ANGLE_MODE, angle);
    reg_write(pidaw_pkg::REG_DEADBAND, dband);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    setting_cnt++;
  endtask

  function automatic int pick_value(int hi, int typical);
    case ($urandom_range(7))
      0: return 0;
      1: return hi;
      default: return $urandom_range(typical);
    endcase
  endfunction

  task automatic random_settings();
    apply_settings(pick_value(65535, 1024), pick_value(65535, 128), pick_value(65535, 1024),
                   pick_value(32767, 32767), pick_value(32767, 32767), $urandom_range(1),
                   pick_value(255, 16));
  endtask

  function automatic void random_sample(output logic signed [DATA_W-1:0] tgt,
                                        output logic signed [DATA_W-1:0] meas);
    int delta;
    int sgn;
    int corners[5] = '{-32768, -1, 0, 1, 32767};
    sgn = $urandom_range(1) ? 1 : -1;
    tgt = DATA_W'($urandom);
    case ($urandom_range(9))
      0, 1: begin
        meas = DATA_W'($urandom);
        return;
      end
      2, 3: delta = sgn * (ENC_COUNTS / 2 - 2 + $urandom_range(4));
      4, 5: delta = sgn * $urandom_range(regs.dband + 1);
      6: begin
        tgt = DATA_W'(corners[$urandom_range(4)]);
        meas = DATA_W'(corners[$urandom_range(4)]);
        return;
      end
      default: delta = sgn * $urandom_range(400);
    endcase
    meas = DATA_W'(int'(tgt) - delta);
  endfunction

  task automatic test_extremes();
    apply_settings(65535, 65535, 65535, 32767, 32767, 0, 255);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_angle_wrap();
    apply_settings(256, 16, 128, 1000, 2000, 1, 3);
    send_error(100, ENC_COUNTS / 2);
    send_error(100, ENC_COUNTS / 2 + 1);
    send_error(100, -ENC_COUNTS / 2);
    send_error(100, -ENC_COUNTS / 2 - 1);
    send_error(-50, 2);
    send_error(-50, -2);
    send_error(-50, 3);
    send_error(-50, -3);
    send_error(0, 0);
    // raw difference beyond one circle still wraps only once
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
  endtask

  task automatic test_deadband_off();
    apply_settings(512, 32, 256, 500, 500, 1, 0);
    send_error(7, 1);
    send_error(7, -1);
  endtask

  task automatic test_zero_limits();
    apply_settings(65535, 65535, 65535, 0, 0, 0, 3);
    send_error(0, 1000);
    send_error(0, -1000);
  endtask

  task automatic test_limit_lowered();
    apply_settings(0, 65535, 0, 32767, 32767, 0, 3);
    send_error(0, 20000);
    send_error(0, 20000);
    // stored integral sits far above the new clamp
    apply_settings(0, 65535, 0, 100, 32767, 0, 3);
    send_error(0, 0);
  endtask

  task automatic test_random_traffic();
    int tx_pct[3] = '{14, 54, 0};
    int rx_pct[3] = '{54, 14, 0};
    logic signed [DATA_W-1:0] tgt;
    logic signed [DATA_W-1:0] meas;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      for (int s = 0; s < 4; s++) begin
        random_settings();
        repeat (145) begin
          random_sample(tgt, meas);
          send_sample(tgt, meas);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    logic signed [DATA_W-1:0] tgt;
    logic signed [DATA_W-1:0] meas;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_settings();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (200) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      repeat (60) begin
        random_sample(tgt, meas);
        send_sample(tgt, meas);
      end
    join
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_angle_wrap();
    test_deadband_off();
    test_zero_limits();
    test_limit_lowered();
    test_random_traffic();
    test_backpressure();
    drain_pipeline();
    $display("%0d samples sent, %0d drive beats checked over %0d register settings",
             sent_cnt, checked_cnt, setting_cnt);
    $display("covered: saturation, angle wrap edges, deadband, zero and lowered limits, stalls");
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pidaw_pkg.sv
design/pidaw_err_front.sv
design/positional_pid_angle_wrap.sv
sim/tb_top.sv
